>>> rtl/bdepq_pkg.sv
// Package for the bounded double-ended priority queues block.
// Types, sizes and event codes shared by front end, back end and top level.
`default_nettype none
package bdepq_pkg;
  localparam int CHANNELS = 8;
  localparam int CAPACITY = 16;
  localparam int CH_W = 3;
  localparam int SL_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SLOTS = CHANNELS * CAPACITY;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int Q_W = 5;
  localparam int CMDQ_DEPTH = 2;

  typedef enum logic [1:0] {
    K_ADD   = 2'd0,
    K_QUOTA = 2'd1,
    K_DROP  = 2'd2,
    K_PRINT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    EV_ADDED    = 3'd0,
    EV_DROPPED  = 3'd1,
    EV_PRINTED  = 3'd2,
    EV_EMPTY    = 3'd3,
    EV_QUOTA    = 3'd4,
    EV_REJECTED = 3'd5
  } event_t;

  // Classified command handed from front end to back end.
  typedef struct packed {
    logic        reject;
    kind_t       kind;
    logic [2:0]  ch;
    logic [15:0] job;
    logic [15:0] pri;
    logic [CNT_W-1:0] quota;
    logic        clip;
  } cmd_t;

  typedef struct packed {
    event_t      ev;
    logic [2:0]  ch;
    logic [15:0] job;
    logic [15:0] value;
    logic        clip;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_DECIDE,
    S_EMIT
  } state_t;
endpackage
`default_nettype wire

>>> rtl/bdepq_front.sv
// Front end: accepts commands, saturates quotas, flags bad channels,
// and buffers them in a short command queue. Depends on bdepq_pkg.
`default_nettype none
module bdepq_front import bdepq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        flush,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_kind,
  input  wire logic [2:0]  in_channel,
  input  wire logic [15:0] in_job_tag,
  input  wire logic [15:0] in_priority_req,
  input  wire logic [15:0] in_new_quota,
  output logic             cmd_valid,
  input  wire logic        cmd_take,
  output cmd_t             cmd
);
  cmd_t q_r [CMDQ_DEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  cmd_t c;

  always_comb begin
    c.reject = (32'(in_channel) >= CHANNELS);
    c.kind   = kind_t'(in_kind);
    c.ch     = in_channel;
    c.job    = in_job_tag;
    c.pri    = in_priority_req;
    c.clip   = (in_new_quota > 16'(CAPACITY));
    c.quota  = c.clip ? CNT_W'(CAPACITY) : in_new_quota[CNT_W-1:0];
  end

  assign in_full   = (cnt_r == 2'(CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  wire do_push = in_push && !in_full;
  wire do_pop  = cmd_valid && cmd_take;
  assign cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
    end
    if (do_push) q_r[wp_r] <= c;
  end
endmodule
`default_nettype wire

>>> rtl/bdepq_back.sv
// Back end: slot memory, per-channel fill and quota, and the scan sequencer.
// Emits result records into the output queue. Depends on bdepq_pkg.
`default_nettype none
module bdepq_back import bdepq_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         init,
  input  wire logic [Q_W-1:0] init_quota,
  input  wire logic         cmd_valid,
  output logic              cmd_take,
  input  cmd_t              cmd,
  output logic              res_valid,
  input  wire logic         res_ready,
  output res_t              res
);
  logic [15:0] mem_job [SLOTS];
  logic [15:0] mem_pri [SLOTS];
  logic [15:0] mem_stamp [SLOTS];
  logic [SLOTS-1:0] valid_r;
  logic [CNT_W-1:0] fill_r [CHANNELS];
  logic [CNT_W-1:0] quota_r [CHANNELS];
  logic [15:0] ctr_r;

  state_t st_r, st_nxt;
  cmd_t   cur_r;
  logic [SL_W:0] idx_r;
  logic   found_r;
  logic [SL_W-1:0] best_r, free_r;
  logic [15:0] bp_r, ba_r;
  logic [15:0] rd_pri_r, rd_stamp_r, rd_job_r;
  logic   rd_ok_r;
  logic [SL_W-1:0] rd_idx_r;
  logic   want_max_r;
  logic   is_add_phase_r; // add: evict done, store pending

  wire [ADDR_W-1:0] base = ADDR_W'(cur_r.ch) * ADDR_W'(CAPACITY);
  wire [ADDR_W-1:0] raddr = base + ADDR_W'(idx_r[SL_W-1:0]);
  wire [CNT_W-1:0] fill_c = fill_r[cur_r.ch];
  wire [CNT_W-1:0] quota_c = quota_r[cur_r.ch];
  wire [15:0] age = ctr_r - rd_stamp_r;
  logic better;

  always_comb begin
    if (!found_r) better = 1'b1;
    else if (rd_pri_r == bp_r) better = age > ba_r;
    else better = want_max_r ? (rd_pri_r > bp_r) : (rd_pri_r < bp_r);
  end

  // best slot including the one being compared this cycle
  wire [SL_W-1:0] best_c = (rd_ok_r && better) ? rd_idx_r : best_r;

  // what to do once a command is loaded or a take has finished
  typedef enum logic [1:0] {A_SCAN, A_STORE, A_FINAL} act_t;
  act_t act;
  always_comb begin
    act = A_FINAL;
    if (!cur_r.reject) begin
      unique case (cur_r.kind)
        K_ADD:   act = (quota_c != '0 && !is_add_phase_r && fill_c >= quota_c)
                       ? A_SCAN : A_FINAL;
        K_QUOTA: act = (fill_c > cur_r.quota) ? A_SCAN : A_FINAL;
        K_DROP, K_PRINT: act = is_add_phase_r ? A_FINAL : A_SCAN;
        default: act = A_FINAL;
      endcase
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:   if (cmd_valid) st_nxt = S_DECIDE;
      S_DECIDE: st_nxt = (act == A_SCAN) ? S_SCAN : S_EMIT;
      S_SCAN:   st_nxt = S_READ;
      S_READ:   if (idx_r == (SL_W+1)'(CAPACITY)) st_nxt = S_EMIT;
      S_EMIT:   if (res_ready) st_nxt = res.last ? S_IDLE : S_DECIDE;
      default:  st_nxt = S_IDLE;
    endcase
  end

  assign cmd_take  = (st_r == S_IDLE);
  assign res_valid = (st_r == S_EMIT);

  // result formation
  always_comb begin
    res.ch   = cur_r.ch;
    res.job  = '0;
    res.value = '0;
    res.clip = 1'b0;
    res.last = 1'b1;
    res.ev   = EV_REJECTED;
    if (idx_r != '0) begin
      // a take just finished
      res.ev   = found_r ? (want_max_r ? EV_PRINTED : EV_DROPPED) : EV_EMPTY;
      res.job  = found_r ? rd_job_r : '0;
      res.last = (cur_r.kind == K_DROP || cur_r.kind == K_PRINT);
    end else if (cur_r.reject || (cur_r.kind == K_ADD && quota_c == '0)) begin
      res.ev = EV_REJECTED; res.job = cur_r.job; res.value = cur_r.pri;
    end else if (cur_r.kind == K_ADD) begin
      res.ev = EV_ADDED; res.job = cur_r.job; res.value = cur_r.pri;
    end else begin
      res.ev = EV_QUOTA; res.value = 16'(cur_r.quota); res.clip = cur_r.clip;
    end
  end

  // best slot job read back for the report
  always_ff @(posedge clk) begin
    if (st_r == S_READ && idx_r == (SL_W+1)'(CAPACITY))
      rd_job_r <= mem_job[base + ADDR_W'(best_c)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= init ? S_IDLE : st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      valid_r <= '0;
      ctr_r   <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        fill_r[i]  <= '0;
        quota_r[i] <= (init_quota > Q_W'(CAPACITY)) ? CNT_W'(CAPACITY)
                                                    : init_quota[CNT_W-1:0];
      end
    end else begin
      // register the scanned slot, one per cycle
      rd_pri_r   <= mem_pri[raddr];
      rd_stamp_r <= mem_stamp[raddr];
      rd_ok_r    <= valid_r[raddr];
      rd_idx_r   <= idx_r[SL_W-1:0];
      unique case (st_r)
        S_IDLE: if (cmd_valid) begin
          cur_r <= cmd;
          is_add_phase_r <= 1'b0;
          idx_r <= '0;
        end
        S_DECIDE: begin
          want_max_r <= (cur_r.kind == K_PRINT);
          found_r <= 1'b0;
          idx_r <= '0;
        end
        S_SCAN: idx_r <= idx_r + (SL_W+1)'(1);
        S_READ: begin
          if (idx_r != (SL_W+1)'(CAPACITY)) idx_r <= idx_r + (SL_W+1)'(1);
          if (rd_ok_r && better) begin
            found_r <= 1'b1; best_r <= rd_idx_r; bp_r <= rd_pri_r; ba_r <= age;
          end
        end
        S_EMIT: if (res_ready) begin
          if (idx_r != '0) begin
            if (found_r) begin
              valid_r[base + ADDR_W'(best_r)] <= 1'b0;
              fill_r[cur_r.ch] <= fill_c - CNT_W'(1);
            end
            is_add_phase_r <= (cur_r.kind != K_QUOTA);
            idx_r <= '0;
          end else if (!cur_r.reject) begin
            if (cur_r.kind == K_ADD && quota_c != '0) begin
              valid_r[base + ADDR_W'(free_r)] <= 1'b1;
              fill_r[cur_r.ch] <= fill_c + CNT_W'(1);
              ctr_r <= ctr_r + 16'd1;
            end else if (cur_r.kind == K_QUOTA) begin
              quota_r[cur_r.ch] <= cur_r.quota;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // free slot: lowest invalid slot of the channel (valid bits are flops)
  always_comb begin
    free_r = '0;
    for (int i = CAPACITY - 1; i >= 0; i--)
      if (!valid_r[base + ADDR_W'(i)]) free_r = SL_W'(i);
  end

  always_ff @(posedge clk) begin
    if (st_r == S_EMIT && res_ready && idx_r == '0 && !cur_r.reject &&
        cur_r.kind == K_ADD && quota_c != '0) begin
      mem_job[base + ADDR_W'(free_r)]   <= cur_r.job;
      mem_pri[base + ADDR_W'(free_r)]   <= cur_r.pri;
      mem_stamp[base + ADDR_W'(free_r)] <= ctr_r;
    end
  end
endmodule
`default_nettype wire

>>> rtl/bounded_double_ended_priority_queues_core.sv
// Bounded double-ended priority queues, one per channel; one command at a time.
// A min/max scan reads the slots of one channel, one slot read per cycle. A drop or
// print takes one scan, an add below quota takes none, an add at quota takes a scan to
// evict first, and a quota change one scan per eviction; result stalls lengthen these.
// Reset (rst_n low, synchronous) or a default_quota write empties all queues.
`default_nettype none
module bounded_double_ended_priority_queues_core import bdepq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_kind,
  input  wire logic [2:0]  in_channel,
  input  wire logic [15:0] in_job_tag,
  input  wire logic [15:0] in_priority_req,
  input  wire logic [15:0] in_new_quota,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       out_event_res,
  output logic [2:0]       out_channel,
  output logic [15:0]      out_job,
  output logic [15:0]      out_value,
  output logic             out_quota_clipped,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data
);
  logic [Q_W-1:0] dq_r;
  logic cmd_valid, cmd_take, res_valid, res_ready;
  cmd_t cmd;
  res_t res, ob_r;
  logic ob_full_r;

  assign cfg_ready = 1'b1;
  wire cfg_wr = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) dq_r <= Q_W'(16);
    else if (cfg_wr) dq_r <= cfg_data;
  end

  // init pulse on a config write; init quota is the new value then, else the stored one
  wire init = cfg_wr;
  wire [Q_W-1:0] iq = cfg_wr ? cfg_data : dq_r;

  bdepq_front u_front (
    .clk, .rst_n, .flush(init),
    .in_push, .in_full, .in_kind, .in_channel, .in_job_tag,
    .in_priority_req, .in_new_quota,
    .cmd_valid, .cmd_take, .cmd
  );

  bdepq_back u_back (
    .clk, .rst_n, .init, .init_quota(iq),
    .cmd_valid, .cmd_take, .cmd,
    .res_valid, .res_ready, .res
  );

  // one-entry output register decouples the result side
  assign res_ready = !ob_full_r || pop;
  always_ff @(posedge clk) begin
    if (!rst_n || init) ob_full_r <= 1'b0;
    else if (res_valid && res_ready) ob_full_r <= 1'b1;
    else if (pop) ob_full_r <= 1'b0;
    if (res_valid && res_ready) ob_r <= res;
  end

  assign empty             = !ob_full_r;
  assign out_event_res     = ob_r.ev;
  assign out_channel       = ob_r.ch;
  assign out_job           = ob_r.job;
  assign out_value         = ob_r.value;
  assign out_quota_clipped = ob_r.clip;
  assign out_last          = ob_r.last;

  a_clip_only_quota: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_quota_clipped) |-> (out_event_res == EV_QUOTA))
    else $error("clip on non-quota event");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n || init)
    (!empty && !pop) |=> (!empty && $stable(out_job)))
    else $error("result lost while stalled");
endmodule
`default_nettype wire
